FILE: hdl/sst_pkg.sv
// Shared types and constants for the sorted set table.
package sst_pkg;

    // Operation codes; code 3 behaves as a lookup
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2
    } sst_op_t;

    // Width of the entry_count result field
    localparam int unsigned COUNT_OUT_W = 5;

    // Shift command broadcast to every cell
    typedef struct packed {
        logic ins_shift;   // insert a new key, shift upper part right
        logic del_shift;   // remove the hit key, shift upper part left
    } sst_cmd_t;

    // Compare status returned by every cell
    typedef struct packed {
        logic lt;          // cell occupied and entry below key
        logic eq;          // cell occupied and entry equal to key
    } sst_stat_t;

endpackage

FILE: hdl/sst_cell.sv
// One slot of the sorted row: holds an entry, compares it, shifts with neighbors.
module sst_cell
    import sst_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 32,
    parameter int unsigned CNT_W       = 5,
    parameter int unsigned INDEX       = 0
)
(
    input  logic                          clk,
    input  sst_cmd_t                      cmd,
    input  logic signed [VALUE_WIDTH-1:0] key,
    input  logic        [CNT_W-1:0]       count,
    input  logic                          left_lt,
    input  logic signed [VALUE_WIDTH-1:0] left_value,
    input  logic signed [VALUE_WIDTH-1:0] right_value,
    output sst_stat_t                     stat,
    output logic signed [VALUE_WIDTH-1:0] value
);

    localparam logic [CNT_W-1:0] SLOT = CNT_W'(INDEX);

    logic                          occupied;
    logic signed [VALUE_WIDTH-1:0] entry_reg;
    logic signed [VALUE_WIDTH-1:0] entry_next;

    // Occupancy follows from the count; entries above it are don't-care
    assign occupied = SLOT < count;
    assign stat.lt  = occupied && (entry_reg < key);
    assign stat.eq  = occupied && (entry_reg == key);
    assign value    = entry_reg;

    // Insert: first slot at or above the key takes the key, the rest take left data.
    // Delete: slots at or above the key take right data.
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins_shift && !stat.lt)
        begin
            entry_next = left_lt ? key : left_value;
        end
        else if (cmd.del_shift && !stat.lt)
        begin
            entry_next = right_value;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

FILE: hdl/sorted_set_table_unit.sv
// Sorted set table: an accepted item's result is registered and held until its transfer.
// Throughput one item per cycle; a new item is taken while the result register
// is empty or being read out in the same cycle.
// Rate is set by one broadcast compare across the cell row plus one shift step.
// Reset clears the stored count and the result valid; entries stay undefined
// and are never read above the count.
module sorted_set_table_unit
    import sst_pkg::*;
#(
    parameter int unsigned CAPACITY    = 16,
    parameter int unsigned VALUE_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         operation,
    input  logic signed [31:0] item_value,
    output logic               result_valid,
    input  logic               result_stall,
    output logic               was_present,
    output logic               dropped_full,
    output logic [COUNT_OUT_W-1:0] entry_count
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    logic                          accept;
    logic signed [VALUE_WIDTH+31:0] value_ext;
    logic signed [VALUE_WIDTH-1:0] key;
    logic                          is_insert;
    logic                          is_delete;
    logic                          hit;
    logic                          full;
    logic                          drop;
    sst_cmd_t                      cmd;
    sst_stat_t                     stat [CAPACITY];
    logic signed [VALUE_WIDTH-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]           lt_vec;
    logic [CAPACITY-1:0]           eq_vec;

    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [CNT_W+COUNT_OUT_W-1:0]  count_ext;
    logic                          result_valid_reg;
    logic                          was_present_reg;
    logic                          dropped_full_reg;
    logic [COUNT_OUT_W-1:0]        entry_count_reg;

    // Input transfer when the result register is free or draining
    assign item_stall = result_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;

    // Key: sign-extend from 32 bits, wrap to the stored width
    assign value_ext = {{VALUE_WIDTH{item_value[31]}}, item_value};
    assign key       = value_ext[VALUE_WIDTH-1:0];

    // Operation decode; code 3 falls through as a lookup
    assign is_insert = operation == OP_INSERT;
    assign is_delete = operation == OP_DELETE;

    // Row of compare-and-shift cells
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                          left_lt;
            logic signed [VALUE_WIDTH-1:0] left_value;
            logic signed [VALUE_WIDTH-1:0] right_value;

            if (gi == 0)
            begin : g_first
                assign left_lt    = 1'b1;
                assign left_value = key;
            end
            else
            begin : g_mid
                assign left_lt    = stat[gi-1].lt;
                assign left_value = cell_value[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_value = cell_value[gi];
            end
            else
            begin : g_inner
                assign right_value = cell_value[gi+1];
            end

            sst_cell #(
                .VALUE_WIDTH (VALUE_WIDTH),
                .CNT_W       (CNT_W),
                .INDEX       (gi)
            ) u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .key         (key),
                .count       (count_reg),
                .left_lt     (left_lt),
                .left_value  (left_value),
                .right_value (right_value),
                .stat        (stat[gi]),
                .value       (cell_value[gi])
            );

            assign lt_vec[gi] = stat[gi].lt;
            assign eq_vec[gi] = stat[gi].eq;
        end
    endgenerate

    // Hit, full and shift commands
    assign hit           = |eq_vec;
    assign full          = count_reg == FULL_COUNT;
    assign drop          = is_insert && !hit && full;
    assign cmd.ins_shift = accept && is_insert && !hit && !full;
    assign cmd.del_shift = accept && is_delete && hit;

    // Count update
    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins_shift)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.del_shift)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_next};

    // Count and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            was_present_reg  <= hit;
            dropped_full_reg <= drop;
            entry_count_reg  <= count_ext[COUNT_OUT_W-1:0];
        end
    end

    assign result_valid = result_valid_reg;
    assign was_present  = was_present_reg;
    assign dropped_full = dropped_full_reg;
    assign entry_count  = entry_count_reg;

    // Count never passes the capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
    else $error("stored count above capacity");

    // No duplicate keys: at most one cell matches
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(eq_vec))
    else $error("duplicate entry in table");

    // Sorted order: below-key cells form a prefix of the row
    assert property (@(posedge clk) disable iff (!rst_n)
        ((lt_vec >> 1) & ~lt_vec) == '0)
    else $error("table row out of order");

    // Count moves only with an accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
    else $error("count changed without an item");

    // Insert of a new value into a full table is flagged as dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && drop |=> result_valid_reg && dropped_full_reg && $stable(count_reg))
    else $error("full insert not dropped");

endmodule

FILE: tb/tb_sorted_set_table_unit.sv
// Self-checking testbench for the sorted set table: random traffic checked against a set predictor.
module tb_sorted_set_table_unit;
    import sst_pkg::*;

    localparam int unsigned SET_CAP     = 16;
    localparam int unsigned POOL_SIZE   = 24;
    localparam int unsigned PHASES      = 14;
    localparam int unsigned PHASE_ITEMS = 98;
    localparam int unsigned IDLE_PCT    = 33;
    localparam int          QUIET_LO    = 700;
    localparam int          QUIET_HI    = 1300;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          MAX_REPORTS = 10;
    // Code 3 is outside the enum; the block treats it as a lookup
    localparam logic [1:0]  OP_SPARE    = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] val;
    } set_req_t;

    typedef struct packed {
        logic                   hit;
        logic                   drop;
        logic [COUNT_OUT_W-1:0] count;
    } set_outcome_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   item_valid = 1'b0;
    logic                   item_stall;
    logic [1:0]             operation = OP_INSERT;
    logic signed [31:0]     item_value = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic                   was_present;
    logic                   dropped_full;
    logic [COUNT_OUT_W-1:0] entry_count;

    // Predictor state: the set contents in ascending order
    logic signed [31:0] set_vals [SET_CAP];
    int                 set_size = 0;

    set_req_t     pending_reqs [$];
    set_outcome_t expected_outcomes [$];

    int cycle_count  = 0;
    int mismatches   = 0;
    int n_accepted   = 0;
    int n_checked    = 0;
    int n_hits       = 0;
    int n_drops      = 0;
    int n_full_turns = 0;
    int n_emptied    = 0;

    sorted_set_table_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .operation    (operation),
        .item_value   (item_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .was_present  (was_present),
        .dropped_full (dropped_full),
        .entry_count  (entry_count)
    );

    // Clock and reset
    initial
    begin
        rst_n = 1'b0;
        fork
            forever #10 clk = ~clk;
            begin
                repeat (5) @(posedge clk);
                rst_n <= 1'b1;
            end
        join_none
    end

    // Idling is off inside the quiet window
    function automatic bit idle_roll();
        if (cycle_count >= QUIET_LO && cycle_count < QUIET_HI)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    // Apply one operation to the predicted set and return its outcome
    function automatic set_outcome_t apply_set_op(logic [1:0] op, logic signed [31:0] v);
        set_outcome_t o;
        int           slot;
        bit           hit;
        slot = 0;
        while (slot < set_size && set_vals[slot] < v)
            slot++;
        hit = 1'b0;
        if (slot < set_size)
            hit = (set_vals[slot] == v);
        o.drop = 1'b0;
        case (op)
            OP_INSERT:
            begin
                if (!hit)
                begin
                    if (set_size >= SET_CAP)
                        o.drop = 1'b1;
                    else
                    begin
                        for (int i = set_size; i > slot; i--)
                            set_vals[i] = set_vals[i-1];
                        set_vals[slot] = v;
                        set_size++;
                        if (set_size == SET_CAP)
                            n_full_turns++;
                    end
                end
            end
            OP_DELETE:
            begin
                if (hit)
                begin
                    for (int i = slot; i < set_size - 1; i++)
                        set_vals[i] = set_vals[i+1];
                    set_size--;
                    if (set_size == 0)
                        n_emptied++;
                end
            end
            default: ;  // lookup and spare code leave the set alone
        endcase
        o.hit   = hit;
        o.count = set_size[COUNT_OUT_W-1:0];
        n_hits  += hit;
        n_drops += o.drop;
        return o;
    endfunction

    // Driver: predicts on each accepted transfer, then loads the next item or idles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            operation  <= OP_INSERT;
            item_value <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                expected_outcomes.push_back(apply_set_op(operation, item_value));
                n_accepted++;
            end
            if (!item_valid || !item_stall)
            begin
                if (pending_reqs.size() > 0 && !idle_roll())
                begin
                    set_req_t req;
                    req = pending_reqs.pop_front();
                    item_valid <= 1'b1;
                    operation  <= req.op;
                    item_value <= req.val;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transfer against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("ERROR cycle %0d: result transfer with none expected", cycle_count);
                end
                else
                begin
                    set_outcome_t exp_o;
                    exp_o = expected_outcomes.pop_front();
                    n_checked++;
                    if (was_present !== exp_o.hit || dropped_full !== exp_o.drop ||
                        entry_count !== exp_o.count)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("ERROR result %0d: exp hit=%0b drop=%0b count=%0d, got hit=%0b drop=%0b count=%0d",
                                     n_checked, exp_o.hit, exp_o.drop, exp_o.count,
                                     was_present, dropped_full, entry_count);
                    end
                end
            end
            result_stall <= idle_roll();
        end
    end

    // Cycle counter and run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, expected_outcomes.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_req(logic [1:0] op, logic [31:0] v);
        set_req_t req;
        req.op  = op;
        req.val = v;
        pending_reqs.push_back(req);
    endtask

    // Hold the sender until every issued item has produced its result;
    // sampled at the falling edge so the driver and monitor updates have settled
    task automatic wait_drained();
        @(negedge clk);
        while (pending_reqs.size() > 0 || item_valid || expected_outcomes.size() > 0)
            @(negedge clk);
    endtask

    // Stimulus
    initial
    begin
        logic [31:0] pool [POOL_SIZE];
        int          ins_pct;
        int          r;
        logic [1:0]  op;
        logic [31:0] v;

        wait (rst_n === 1'b1);

        // Directed: extremes, duplicates, misses and the spare code
        push_req(OP_LOOKUP, 32'h0000_0000);  // lookup on empty set
        push_req(OP_DELETE, 32'h0000_0000);  // delete on empty set
        push_req(OP_INSERT, 32'h8000_0000);
        push_req(OP_INSERT, 32'h7FFF_FFFF);
        push_req(OP_INSERT, 32'h0000_0000);
        push_req(OP_INSERT, 32'hFFFF_FFFF);
        push_req(OP_INSERT, 32'h5555_5555);
        push_req(OP_INSERT, 32'hAAAA_AAAA);
        push_req(OP_INSERT, 32'h0000_0000);  // duplicate insert
        push_req(OP_LOOKUP, 32'hFFFF_FFFF);
        push_req(OP_LOOKUP, 32'h0000_0001);  // miss
        push_req(OP_SPARE,  32'h7FFF_FFFF);  // spare code on a stored value
        push_req(OP_SPARE,  32'h0000_0002);
        push_req(OP_DELETE, 32'h0000_0005);  // delete of absent value
        push_req(OP_DELETE, 32'h8000_0000);  // lowest entry
        push_req(OP_DELETE, 32'h7FFF_FFFF);  // highest entry
        push_req(OP_LOOKUP, 32'h8000_0000);
        push_req(OP_DELETE, 32'h5555_5555);  // highest remaining entry
        push_req(OP_LOOKUP, 32'hAAAA_AAAA);
        push_req(OP_INSERT, 32'h8000_0001);
        wait_drained();

        // Random: alternating fill-heavy and drain-heavy phases over a small value pool
        for (int p = 0; p < PHASES; p++)
        begin
            if (p % 4 == 0)
            begin
                pool[0] = 32'h8000_0000;
                pool[1] = 32'h7FFF_FFFF;
                pool[2] = 32'h0000_0000;
                pool[3] = 32'hFFFF_FFFF;
                for (int k = 4; k < POOL_SIZE; k++)
                    pool[k] = (k % 2) ? $urandom : 32'($urandom_range(0, 40)) - 32'd20;
            end
            ins_pct = (p % 2 == 0) ? 65 : 25;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < ins_pct)
                    op = OP_INSERT;
                else if (r < 80)
                    op = OP_DELETE;
                else if (r < 97)
                    op = OP_LOOKUP;
                else
                    op = OP_SPARE;
                if ($urandom_range(0, 99) < 85)
                    v = pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    v = $urandom;
                push_req(op, v);
            end
            // Let everything in flight settle once midway
            if (p == PHASES / 2)
                wait_drained();
        end

        wait_drained();
        repeat (10) @(posedge clk);

        $display("Checked %0d results from %0d transfers: %0d hits, %0d dropped inserts",
                 n_checked, n_accepted, n_hits, n_drops);
        $display("Set reached full %0d times and emptied %0d times", n_full_turns, n_emptied);
        if (mismatches == 0)
            $display("No mismatches found");
        else
        begin
            $display("%0d mismatching results", mismatches);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
